### sv/ghc_pkg.sv
`timescale 1ns / 1ps
package ghc_pkg;

  localparam int unsigned DEBOUNCE_W = 10;
  localparam int unsigned TEMP_W     = 12;
  localparam int unsigned HYST_W     = 8;
  localparam int unsigned HUMID_W    = 10;
  localparam int unsigned LEVEL_W    = 10;
  localparam int unsigned SOIL_W     = 7;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CLICK_W    = 3;
  localparam int unsigned ACT_BTNS   = 4;

  // Remote command codes; codes above CMD_SET_LEVELS are ignored.
  typedef enum logic [3:0] {
    CMD_NONE       = 4'd0,
    CMD_AUTO       = 4'd1,
    CMD_MANUAL     = 4'd2,
    CMD_PUMP_START = 4'd3,
    CMD_PUMP_STOP  = 4'd4,
    CMD_FAN_START  = 4'd5,
    CMD_FAN_STOP   = 4'd6,
    CMD_WIN_OPEN   = 4'd7,
    CMD_WIN_CLOSE  = 4'd8,
    CMD_SET_LEVELS = 4'd9
  } cmd_e;

  typedef enum logic [2:0] {
    REG_DEBOUNCE   = 3'd0,
    REG_TEMP_ON    = 3'd1,
    REG_TEMP_HYST  = 3'd2,
    REG_HUMID_OPEN = 3'd3,
    REG_HUMID_HYST = 3'd4
  } reg_e;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_on;
    logic [HYST_W-1:0]        temp_hyst;
    logic [HUMID_W-1:0]       humid_open;
    logic [HYST_W-1:0]        humid_hyst;
  } cfg_t;

  typedef struct packed {
    logic               pump;
    logic               fan;
    logic               window;
    logic               manual;
    logic               alarm;
    logic [CLICK_W-1:0] clicks;
    logic               beep;
  } res_t;

endpackage

### sv/ghc_debounce_lane.sv
`timescale 1ns / 1ps
module ghc_debounce_lane (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic                           level_i,
  input  logic [ghc_pkg::TIME_W-1:0]     now_i,
  input  logic [ghc_pkg::DEBOUNCE_W-1:0] debounce_ms_i,
  output logic                           fire_o
);
  import ghc_pkg::*;

  logic              level_q, level_d;
  logic              fired_q, fired_d;
  logic [TIME_W-1:0] stamp_q, stamp_d;
  logic [TIME_W-1:0] elapsed;

  assign elapsed = now_i - stamp_q;

  always_comb begin
    level_d = level_q;
    fired_d = fired_q;
    stamp_d = stamp_q;
    fire_o  = 1'b0;
    if (level_i != level_q) begin
      // level changed: restart timer and re-arm
      level_d = level_i;
      stamp_d = now_i;
      fired_d = 1'b0;
    end else if (!level_i && !fired_q &&
                 (elapsed > {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ms_i})) begin
      fired_d = 1'b1;
      fire_o  = step_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b1;
      fired_q <= 1'b0;
      stamp_q <= '0;
    end else if (step_i) begin
      level_q <= level_d;
      fired_q <= fired_d;
      stamp_q <= stamp_d;
    end
  end

endmodule

### sv/ghc_ctrl.sv
`timescale 1ns / 1ps
module ghc_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               step_i,
  input  ghc_pkg::cfg_t                      cfg_i,
  input  logic [ghc_pkg::ACT_BTNS-1:0]       fire_i,
  input  logic [3:0]                         cmd_i,
  input  logic [ghc_pkg::LEVEL_W-1:0]        new_low_i,
  input  logic [ghc_pkg::LEVEL_W-1:0]        new_high_i,
  input  logic                               on_backup_i,
  input  logic [ghc_pkg::SOIL_W-1:0]         soil_pct_i,
  input  logic signed [ghc_pkg::TEMP_W-1:0]  temp_i,
  input  logic [ghc_pkg::HUMID_W-1:0]        humid_i,
  output ghc_pkg::res_t                      res_o
);
  import ghc_pkg::*;

  localparam logic [LEVEL_W-1:0] SOIL_LOW_RST  = LEVEL_W'(300);
  localparam logic [LEVEL_W-1:0] SOIL_HIGH_RST = LEVEL_W'(700);

  logic manual_q, manual_d, pump_q, pump_d, fan_q, fan_d;
  logic window_q, window_d, backup_q, backup_d, alarm_q, alarm_d;
  logic [LEVEL_W-1:0] low_q, low_d, high_q, high_d;

  logic               entry, leave;
  logic [LEVEL_W:0]   soil10;
  logic               soil_ok, soil_dry, soil_wet;
  logic signed [TEMP_W:0]  temp_off;
  logic signed [HUMID_W:0] humid_close, humid_s;
  logic [CLICK_W-1:0] clicks;

  assign soil10 = ({4'b0, soil_pct_i} << 3) + ({4'b0, soil_pct_i} << 1);
  assign temp_off = {cfg_i.temp_on[TEMP_W-1], cfg_i.temp_on}
                  - $signed({{(TEMP_W+1-HYST_W){1'b0}}, cfg_i.temp_hyst});
  assign humid_close = $signed({1'b0, cfg_i.humid_open})
                     - $signed({{(HUMID_W+1-HYST_W){1'b0}}, cfg_i.humid_hyst});
  assign humid_s = $signed({1'b0, humid_i});

  always_comb begin
    manual_d = manual_q;
    pump_d   = pump_q;
    fan_d    = fan_q;
    window_d = window_q;
    backup_d = backup_q;
    alarm_d  = alarm_q;
    low_d    = low_q;
    high_d   = high_q;

    // supply transitions
    entry = on_backup_i && !backup_q;
    leave = !on_backup_i && backup_q;
    if (entry) begin
      backup_d = 1'b1;
      fan_d    = 1'b0;
      window_d = 1'b0;
    end
    if (leave) begin
      backup_d = 1'b0;
    end

    // merge lane results: each button owns its own target
    clicks = CLICK_W'(leave) + CLICK_W'(fire_i[0]) + CLICK_W'(fire_i[1])
           + CLICK_W'(fire_i[2] && !alarm_q) + CLICK_W'(fire_i[3]);
    if (fire_i[0]) manual_d = !manual_d;
    if (fire_i[1]) pump_d = !pump_d;
    if (fire_i[2]) alarm_d = 1'b0;
    if (fire_i[3]) begin
      if (fan_d || window_d) begin
        fan_d    = 1'b0;
        window_d = 1'b0;
      end else begin
        fan_d    = 1'b1;
        window_d = 1'b1;
      end
    end

    unique case (cmd_e'(cmd_i))
      CMD_AUTO:       manual_d = 1'b0;
      CMD_MANUAL:     manual_d = 1'b1;
      CMD_PUMP_START: begin manual_d = 1'b1; pump_d = 1'b1; end
      CMD_PUMP_STOP:  begin manual_d = 1'b1; pump_d = 1'b0; end
      CMD_FAN_START:  begin manual_d = 1'b1; fan_d = 1'b1; end
      CMD_FAN_STOP:   begin manual_d = 1'b1; fan_d = 1'b0; end
      CMD_WIN_OPEN:   begin manual_d = 1'b1; window_d = 1'b1; end
      CMD_WIN_CLOSE:  begin manual_d = 1'b1; window_d = 1'b0; end
      CMD_SET_LEVELS: begin low_d = new_low_i; high_d = new_high_i; end
      default:        ;
    endcase

    soil_ok  = (soil10 != '0);
    soil_dry = soil10 < {1'b0, low_d};
    soil_wet = soil10 > {1'b0, high_d};

    if (!manual_d && soil_ok) begin
      if (soil_dry && !pump_d) pump_d = 1'b1;
      else if (soil_wet && pump_d) pump_d = 1'b0;
    end

    if (soil_ok && soil_dry && !alarm_d) alarm_d = 1'b1;
    else if (soil_wet && alarm_d && !pump_d) alarm_d = 1'b0;

    if (!manual_d && (temp_i > $signed(TEMP_W'(0)))) begin
      if ((temp_i > cfg_i.temp_on) && !fan_d) fan_d = 1'b1;
      else if (($signed({temp_i[TEMP_W-1], temp_i}) < temp_off) && fan_d) fan_d = 1'b0;
      if ((humid_i > cfg_i.humid_open) && !window_d) window_d = 1'b1;
      else if ((humid_s < humid_close) && window_d) window_d = 1'b0;
    end

    res_o.pump   = pump_d;
    res_o.fan    = fan_d;
    res_o.window = window_d;
    res_o.manual = manual_d;
    res_o.alarm  = alarm_d;
    res_o.clicks = clicks;
    res_o.beep   = entry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      manual_q <= 1'b0;
      pump_q   <= 1'b0;
      fan_q    <= 1'b0;
      window_q <= 1'b0;
      backup_q <= 1'b0;
      alarm_q  <= 1'b0;
      low_q    <= SOIL_LOW_RST;
      high_q   <= SOIL_HIGH_RST;
    end else if (step_i) begin
      manual_q <= manual_d;
      pump_q   <= pump_d;
      fan_q    <= fan_d;
      window_q <= window_d;
      backup_q <= backup_d;
      alarm_q  <= alarm_d;
      low_q    <= low_d;
      high_q   <= high_d;
    end
  end

endmodule

### sv/greenhouse_hysteresis_controller_unit.sv
`timescale 1ns / 1ps
// A result is registered and appears on the master side in the cycle after its request is accepted.
// Throughput: one request per cycle; the single output register frees up in the cycle
// its result is taken, so s_axis_tready only drops while that register is full and stalled.
// Reset (rst_ni low, asynchronous): automatic mode, all actuators off, alarm clear,
// soil levels 300/700, buttons released, configuration registers at their defaults.
module greenhouse_hysteresis_controller_unit #(
  parameter int unsigned NUM_BUTTONS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] cmd, [13:4] new_low_level, [23:14] new_high_level, [55:24] now_ms,
  // [59:56] buttons_raw, [60] on_backup, [67:61] soil_pct, [79:68] temp_tenths,
  // [89:80] humid_tenths, [95:90] zero
  input  logic [95:0] s_axis_tdata,
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] pump_state, [1] fan_state, [2] window_state, [3] manual_state,
  // [4] alarm_state, [7:5] click_count, [8] long_beep, [15:9] zero
  output logic [15:0] m_axis_tdata,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [11:0] cfg_wdata_i
);
  import ghc_pkg::*;

  localparam logic [DEBOUNCE_W-1:0]   DEBOUNCE_RST   = DEBOUNCE_W'(50);
  localparam logic signed [TEMP_W-1:0] TEMP_ON_RST   = TEMP_W'(350);
  localparam logic [HYST_W-1:0]       TEMP_HYST_RST  = HYST_W'(30);
  localparam logic [HUMID_W-1:0]      HUMID_OPEN_RST = HUMID_W'(800);
  localparam logic [HYST_W-1:0]       HUMID_HYST_RST = HYST_W'(50);

  // Configuration registers
  logic [DEBOUNCE_W-1:0] debounce_q;
  cfg_t                  cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q       <= DEBOUNCE_RST;
      cfg_q.temp_on    <= TEMP_ON_RST;
      cfg_q.temp_hyst  <= TEMP_HYST_RST;
      cfg_q.humid_open <= HUMID_OPEN_RST;
      cfg_q.humid_hyst <= HUMID_HYST_RST;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_addr_i))
        REG_DEBOUNCE:   debounce_q       <= cfg_wdata_i[DEBOUNCE_W-1:0];
        REG_TEMP_ON:    cfg_q.temp_on    <= $signed(cfg_wdata_i[TEMP_W-1:0]);
        REG_TEMP_HYST:  cfg_q.temp_hyst  <= cfg_wdata_i[HYST_W-1:0];
        REG_HUMID_OPEN: cfg_q.humid_open <= cfg_wdata_i[HUMID_W-1:0];
        REG_HUMID_HYST: cfg_q.humid_hyst <= cfg_wdata_i[HYST_W-1:0];
        default:        ;  // drop writes beyond the register list
      endcase
    end
  end

  // Handshake: advance whenever the output register is empty or being drained
  logic out_valid_q;
  res_t out_q;
  res_t res;
  logic step;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  // Unpack the request
  logic [3:0]                cmd;
  logic [LEVEL_W-1:0]        new_low, new_high;
  logic [TIME_W-1:0]         now_ms;
  logic [ACT_BTNS-1:0]       buttons_raw;
  logic                      on_backup;
  logic [SOIL_W-1:0]         soil_pct;
  logic signed [TEMP_W-1:0]  temp_tenths;
  logic [HUMID_W-1:0]        humid_tenths;

  assign cmd          = s_axis_tdata[3:0];
  assign new_low      = s_axis_tdata[13:4];
  assign new_high     = s_axis_tdata[23:14];
  assign now_ms       = s_axis_tdata[55:24];
  assign buttons_raw  = s_axis_tdata[59:56];
  assign on_backup    = s_axis_tdata[60];
  assign soil_pct     = s_axis_tdata[67:61];
  assign temp_tenths  = $signed(s_axis_tdata[79:68]);
  assign humid_tenths = s_axis_tdata[89:80];

  // One debounce lane per button; buttons without an input line read as released
  logic [NUM_BUTTONS-1:0] fire;
  logic [ACT_BTNS-1:0]    fire_act;

  for (genvar k = 0; k < NUM_BUTTONS; k++) begin : g_lane
    logic level;
    if (k < ACT_BTNS) begin : g_wired
      assign level = buttons_raw[k];
    end else begin : g_open
      assign level = 1'b1;
    end
    ghc_debounce_lane u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .step_i        (step),
      .level_i       (level),
      .now_i         (now_ms),
      .debounce_ms_i (debounce_q),
      .fire_o        (fire[k])
    );
  end

  // Only the first four buttons carry actions
  for (genvar k = 0; k < ACT_BTNS; k++) begin : g_act
    if (k < NUM_BUTTONS) begin : g_on
      assign fire_act[k] = fire[k];
    end else begin : g_off
      assign fire_act[k] = 1'b0;
    end
  end

  // Merge lane results with supply, command and hysteresis control
  ghc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .cfg_i       (cfg_q),
    .fire_i      (fire_act),
    .cmd_i       (cmd),
    .new_low_i   (new_low),
    .new_high_i  (new_high),
    .on_backup_i (on_backup),
    .soil_pct_i  (soil_pct),
    .temp_i      (temp_tenths),
    .humid_i     (humid_tenths),
    .res_o       (res)
  );

  // Output register: load on accept, hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_q.beep, out_q.clicks, out_q.alarm, out_q.manual,
                          out_q.window, out_q.fan, out_q.pump};

endmodule
